// ===== hw/rtl/publish_confirm_tag_tracker_core_macros.svh =====
// Assertion macros shared by the checker of the confirm tag tracker.
`ifndef PUBLISH_CONFIRM_TAG_TRACKER_CORE_MACROS_SVH
`define PUBLISH_CONFIRM_TAG_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while arst_n is low.
`define PCTT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tag tracker check failed");

// Next-cycle implication, sampled on clk and switched off while arst_n is low.
`define PCTT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tag tracker check failed");

`endif

// ===== hw/rtl/pctt_pkg.sv =====
// Types, codes and default sizes shared by the confirm tag tracker modules.
package pctt_pkg;

	localparam int LIST_DEPTH_DEF = 64;
	localparam int TAG_BITS_DEF   = 32;
	localparam int TAG_FIELD_W    = 32;
	localparam int OUT_CNT_W      = 7;
	localparam int S_DATA_W       = 40;
	localparam int S_USER_W       = 3;
	localparam int M_DATA_W       = 48;

	typedef enum logic [2:0] {
		REQ_PUBLISH    = 3'd0,
		REQ_ACK        = 3'd1,
		REQ_NACK       = 3'd2,
		REQ_ENABLE     = 3'd3,
		REQ_DISCONNECT = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_APPEND,
		CMD_COMPARE,
		CMD_SHIFT_TAIL,
		CMD_SHIFT_ALL
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIND,
		ST_DROP_ALL,
		ST_RESULT
	} state_t;

	typedef struct packed {
		cmd_t cmd;
		logic occupied;
		logic append_sel;
	} cell_ctrl_t;

	typedef struct packed {
		logic head_match;
		logic any_match;
	} chain_stat_t;

endpackage

// ===== hw/rtl/pctt_cell.sv =====
// One list cell: holds a tag and its match flag, and takes its neighbour's on a shift.
module pctt_cell #(
	parameter int TAG_BITS = pctt_pkg::TAG_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pctt_pkg::cell_ctrl_t ctrl,
	input  logic [TAG_BITS-1:0]  want,
	input  logic [TAG_BITS-1:0]  new_tag,
	input  logic [TAG_BITS-1:0]  nxt_tag,
	input  logic                 nxt_match,
	input  logic                 seen_in,
	output logic                 seen_out,
	output logic [TAG_BITS-1:0]  tag,
	output logic                 match
);
	import pctt_pkg::*;

	logic [TAG_BITS-1:0] tag_q;
	logic                match_q;

	// A cell at or after the first match moves up by one on a single drop.
	assign seen_out = seen_in | match_q;
	assign tag      = tag_q;
	assign match    = match_q;

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			CMD_APPEND: begin
				if (ctrl.append_sel) begin
					tag_q <= new_tag;
				end
			end
			CMD_SHIFT_TAIL: begin
				if (seen_out) begin
					tag_q <= nxt_tag;
				end
			end
			CMD_SHIFT_ALL: tag_q <= nxt_tag;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else begin
			case (ctrl.cmd)
				CMD_COMPARE:   match_q <= ctrl.occupied && (tag_q == want);
				CMD_SHIFT_ALL: match_q <= nxt_match;
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/pctt_chain.sv =====
// The row of list cells, with occupancy decode and the match summary.
module pctt_chain #(
	parameter int LIST_DEPTH = pctt_pkg::LIST_DEPTH_DEF,
	parameter int TAG_BITS   = pctt_pkg::TAG_BITS_DEF,
	localparam int CW        = $clog2(LIST_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pctt_pkg::cmd_t        cmd,
	input  logic [CW-1:0]         count,
	input  logic [TAG_BITS-1:0]   want,
	input  logic [TAG_BITS-1:0]   new_tag,
	output pctt_pkg::chain_stat_t stat
);
	import pctt_pkg::*;

	logic [TAG_BITS-1:0] tag_w [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] match_v;
	logic [LIST_DEPTH:0]   seen_v;

	assign seen_v[0]       = 1'b0;
	assign stat.head_match = match_v[0];
	assign stat.any_match  = |match_v;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		cell_ctrl_t          ctrl;
		logic [TAG_BITS-1:0] nxt_tag;
		logic                nxt_match;

		assign ctrl.cmd        = cmd;
		assign ctrl.occupied   = (CW'(i) < count);
		assign ctrl.append_sel = (CW'(i) == count);

		if (i == LIST_DEPTH - 1) begin : g_last
			assign nxt_tag   = '0;
			assign nxt_match = 1'b0;
		end else begin : g_mid
			assign nxt_tag   = tag_w[i+1];
			assign nxt_match = match_v[i+1];
		end

		pctt_cell #(
			.TAG_BITS(TAG_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.want     (want),
			.new_tag  (new_tag),
			.nxt_tag  (nxt_tag),
			.nxt_match(nxt_match),
			.seen_in  (seen_v[i]),
			.seen_out (seen_v[i+1]),
			.tag      (tag_w[i]),
			.match    (match_v[i])
		);
	end

endmodule

// ===== hw/rtl/publish_confirm_tag_tracker_core.sv =====
// Top level of the publisher-confirm tag tracker: control, counters and result register.
//
// Channel  Dir  Handshake            Contents
// s_*      in   s_tvalid / s_tready  one request word: kind in tuser, tag and flag in tdata
// m_*      out  m_tvalid / m_tready  one result word per request
//
// A request passes three steps from acceptance to its result word being loaded: IDLE
// takes the word, EXEC executes it, RESULT loads the output register. An ack with a
// nonzero tag has every cell compare its tag in parallel in EXEC, then passes FIND, and
// with multiple set the row of cells shifts down by one entry per cycle until the
// matching entry has left the head.
// Reset clears the counters and the control; no clearing pass runs over the cells.
// A stalled output holds the finished word and the block waits with its result until
// the output register is free; s_tready is high only while no request is in hand.
module publish_confirm_tag_tracker_core #(
	parameter int LIST_DEPTH = pctt_pkg::LIST_DEPTH_DEF,
	parameter int TAG_BITS   = pctt_pkg::TAG_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// tdata, lowest bit up: delivery_tag[31:0], multiple[32], zero fill[39:33].
	input  logic [pctt_pkg::S_DATA_W-1:0] s_tdata,
	// tuser: req_type[2:0].
	input  logic [pctt_pkg::S_USER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// tdata, lowest bit up: assigned_tag[31:0], tag_matched[32], all_delivered[33],
	// table_full[34], outstanding_count[41:35], zero fill[47:42].
	output logic [pctt_pkg::M_DATA_W-1:0] m_tdata
);
	import pctt_pkg::*;

	localparam int CW = $clog2(LIST_DEPTH + 1);

	state_t state_q, state_d;

	logic [S_USER_W-1:0]    req_q;
	logic [TAG_FIELD_W-1:0] dtag_q;
	logic                   mult_q;
	logic [TAG_FIELD_W-1:0] assigned_q, assigned_d;
	logic                   matched_q, matched_d;
	logic                   full_q, full_d;
	logic [CW-1:0]          count_q, count_d;
	logic [TAG_BITS-1:0]    next_tag_q, next_tag_d;
	logic                   m_valid_q;
	logic [M_DATA_W-1:0]    m_data_q;

	logic                   s_accept;
	logic                   out_free;
	logic                   load_out;
	cmd_t                   cmd;
	chain_stat_t            stat;
	logic [TAG_BITS-1:0]    want;
	logic [TAG_FIELD_W-1:0] next_tag_out;
	logic [OUT_CNT_W-1:0]   out_count;
	logic                   all_delivered;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// The search compares at the tag width of the list; the reported tag is 32 bits.
	if (TAG_BITS > TAG_FIELD_W) begin : g_wide_tag
		assign want         = {{(TAG_BITS - TAG_FIELD_W){1'b0}}, dtag_q};
		assign next_tag_out = next_tag_q[TAG_FIELD_W-1:0];
	end else if (TAG_BITS == TAG_FIELD_W) begin : g_same_tag
		assign want         = dtag_q;
		assign next_tag_out = next_tag_q;
	end else begin : g_narrow_tag
		assign want         = dtag_q[TAG_BITS-1:0];
		assign next_tag_out = {{(TAG_FIELD_W - TAG_BITS){1'b0}}, next_tag_q};
	end

	if (CW >= OUT_CNT_W) begin : g_cnt_trunc
		assign out_count = count_q[OUT_CNT_W-1:0];
	end else begin : g_cnt_ext
		assign out_count = {{(OUT_CNT_W - CW){1'b0}}, count_q};
	end

	// All delivered is only ever reported for an ack that matched and emptied the list.
	assign all_delivered = matched_q && (count_q == '0);

	pctt_chain #(
		.LIST_DEPTH(LIST_DEPTH),
		.TAG_BITS  (TAG_BITS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.count  (count_q),
		.want   (want),
		.new_tag(next_tag_q),
		.stat   (stat)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if ((req_q == REQ_ACK) && (dtag_q != '0)) begin
					state_d = ST_FIND;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_FIND: begin
				if (stat.any_match && mult_q && !stat.head_match) begin
					state_d = ST_DROP_ALL;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_DROP_ALL: begin
				if (stat.head_match) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Cell commands and the next values of the counters and result flags.
	always_comb begin
		cmd        = CMD_HOLD;
		count_d    = count_q;
		next_tag_d = next_tag_q;
		assigned_d = assigned_q;
		matched_d  = matched_q;
		full_d     = full_q;
		load_out   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					assigned_d = '0;
					matched_d  = 1'b0;
					full_d     = 1'b0;
				end
			end
			ST_EXEC: begin
				case (req_q)
					REQ_PUBLISH: begin
						// Publishes are only recorded while confirms are on.
						if (next_tag_q != '0) begin
							if (count_q == CW'(LIST_DEPTH)) begin
								full_d = 1'b1;
							end else begin
								cmd        = CMD_APPEND;
								count_d    = count_q + CW'(1);
								assigned_d = next_tag_out;
								// The counter skips zero when it wraps.
								if (&next_tag_q) begin
									next_tag_d = TAG_BITS'(1);
								end else begin
									next_tag_d = next_tag_q + TAG_BITS'(1);
								end
							end
						end
					end
					REQ_ACK: begin
						if (dtag_q == '0) begin
							count_d   = '0;
							matched_d = 1'b1;
						end else begin
							cmd = CMD_COMPARE;
						end
					end
					REQ_ENABLE: begin
						if (next_tag_q == '0) begin
							next_tag_d = TAG_BITS'(1);
						end
					end
					REQ_DISCONNECT: count_d = '0;
					default: ;
				endcase
			end
			ST_FIND: begin
				// An unknown tag leaves the list and the flags as they are.
				if (stat.any_match) begin
					matched_d = 1'b1;
					count_d   = count_q - CW'(1);
					cmd       = mult_q ? CMD_SHIFT_ALL : CMD_SHIFT_TAIL;
				end
			end
			ST_DROP_ALL: begin
				cmd     = CMD_SHIFT_ALL;
				count_d = count_q - CW'(1);
			end
			ST_RESULT: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			next_tag_q <= '0;
			m_valid_q  <= 1'b0;
			matched_q  <= 1'b0;
			full_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			next_tag_q <= next_tag_d;
			matched_q  <= matched_d;
			full_q     <= full_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		assigned_q <= assigned_d;
		if (s_accept) begin
			req_q  <= s_tuser;
			dtag_q <= s_tdata[TAG_FIELD_W-1:0];
			mult_q <= s_tdata[TAG_FIELD_W];
		end
		if (load_out) begin
			m_data_q <= {(M_DATA_W - TAG_FIELD_W - OUT_CNT_W - 3)'(0), out_count, full_q,
				all_delivered, matched_q, assigned_q};
		end
	end

endmodule

// ===== hw/rtl/pctt_checker.sv =====
// Port-level checks on the confirm tag tracker, bound to its top level.
module pctt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [pctt_pkg::M_DATA_W-1:0] m_tdata
);
	import pctt_pkg::*;

`include "publish_confirm_tag_tracker_core_macros.svh"

	// A result word that is not taken stays put.
	`PCTT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// One request at a time: the block is busy in the cycle after it takes a word.
	`PCTT_ASSERT_NXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)

	// A dropped publish never reports a tag.
	`PCTT_ASSERT_IMP(a_full_no_tag, m_tvalid && m_tdata[34], m_tdata[31:0] == '0)

	// All delivered only follows a matched ack that left nothing outstanding.
	`PCTT_ASSERT_IMP(a_all_empty, m_tvalid && m_tdata[33],
		m_tdata[32] && (m_tdata[41:35] == '0) && !m_tdata[34])

endmodule

bind publish_confirm_tag_tracker_core pctt_checker u_pctt_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
